// File: src/phd_pkg.sv
// Shared types and constants of the planar hold-and-modify pixel decoder.
`timescale 1ns / 1ps

package phd_pkg;

	// Palette and plane limits
	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_PLANES    = 8;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int PAL_IDX_W     = 8;
	localparam int COLOR_W       = 24;

	// Queue sizes
	localparam int IN_DEPTH  = 2;
	localparam int IN_PW     = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
	localparam int IN_CW     = $clog2(IN_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DW    = 4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HAM_ENABLE  = 4'd1;

	typedef enum logic {
		REQ_PAL_WRITE = 1'b0,
		REQ_PIXELS    = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t   kind;
		logic        row_start;
		logic [63:0] plane_bytes;
		logic [7:0]  pal_index;
		logic [7:0]  pal_red;
		logic [7:0]  pal_green;
		logic [7:0]  pal_blue;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pix_t;

	typedef struct packed {
		logic [3:0] plane_count;
		logic       ham_enable;
	} cfg_t;

endpackage

// File: src/phd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module phd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/phd_front.sv
// Front end: accepts and classifies requests into a short item queue.
`timescale 1ns / 1ps

module phd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic           req_type,
	input  logic           row_start,
	input  logic [63:0]    plane_bytes,
	input  logic [7:0]     pal_index,
	input  logic [7:0]     pal_red,
	input  logic [7:0]     pal_green,
	input  logic [7:0]     pal_blue,
	output logic           head_valid,
	output phd_pkg::item_t head,
	input  logic           head_pop
);

	phd_pkg::item_t                   slot_q [phd_pkg::IN_DEPTH];
	logic [phd_pkg::IN_PW-1:0]        wr_ptr_q;
	logic [phd_pkg::IN_PW-1:0]        rd_ptr_q;
	logic [phd_pkg::IN_CW-1:0]        count_q;
	logic                             do_push;
	logic                             do_pop;
	phd_pkg::item_t                   new_item;

	assign full       = (count_q == phd_pkg::IN_CW'(phd_pkg::IN_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	// classify the incoming transaction
	always_comb begin
		new_item.kind        = req_type ? phd_pkg::REQ_PIXELS : phd_pkg::REQ_PAL_WRITE;
		new_item.row_start   = row_start;
		new_item.plane_bytes = plane_bytes;
		new_item.pal_index   = pal_index;
		new_item.pal_red     = pal_red;
		new_item.pal_green   = pal_green;
		new_item.pal_blue    = pal_blue;
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == phd_pkg::IN_PW'(phd_pkg::IN_DEPTH - 1)) ? '0
				            : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == phd_pkg::IN_PW'(phd_pkg::IN_DEPTH - 1)) ? '0
				            : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/phd_out_queue.sv
// Result queue between the pixel engine and the output ports.
`timescale 1ns / 1ps

module phd_out_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  phd_pkg::pix_t              wr_data,
	output logic [phd_pkg::OUT_CW-1:0] level,
	output logic                       empty,
	input  logic                       pop,
	output phd_pkg::pix_t              head
);

	phd_pkg::pix_t                slot_q [phd_pkg::OUT_DEPTH];
	logic [phd_pkg::OUT_PW-1:0]   wr_ptr_q;
	logic [phd_pkg::OUT_PW-1:0]   rd_ptr_q;
	logic [phd_pkg::OUT_CW-1:0]   count_q;
	logic                         do_pop;

	assign level  = count_q;
	assign empty  = (count_q == '0);
	assign head   = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == phd_pkg::OUT_PW'(phd_pkg::OUT_DEPTH - 1)) ? '0
				            : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == phd_pkg::OUT_PW'(phd_pkg::OUT_DEPTH - 1)) ? '0
				            : rd_ptr_q + 1'b1;
			end
			if (wr_en && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/phd_back.sv
// Back end: palette writes, per-pixel index build, palette read and held-colour update.
`timescale 1ns / 1ps

module phd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  phd_pkg::cfg_t              cfg,
	input  logic                       head_valid,
	input  phd_pkg::item_t             head,
	output logic                       head_pop,
	input  logic [phd_pkg::OUT_CW-1:0] out_level,
	output logic                       out_push,
	output phd_pkg::pix_t              out_data
);

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_MOD_B,
		OP_MOD_R,
		OP_MOD_G,
		OP_KEEP
	} op_t;

	localparam logic [3:0] HAM8_PLANES = 4'd8;
	localparam logic [3:0] HAM6_PLANES = 4'd6;

	// sequencer and issue-side signals
	logic [2:0]                    bit_q;
	logic [3:0]                    planes;
	logic [2:0]                    sel;
	logic [7:0]                    colour;
	logic [phd_pkg::PAL_IDX_W-1:0] ld_idx;
	logic [5:0]                    hd;
	op_t                           op;
	logic                          oob;
	logic                          wide;
	logic                          credit_ok;
	logic                          pix_go;
	logic                          wr_go;
	logic                          wr_in_range;

	// pixel stage registers
	logic                          valid_s1;
	op_t                           op_s1;
	logic [5:0]                    hd_s1;
	logic                          wide_s1;
	logic                          reload_s1;
	logic                          last_s1;
	logic                          oob_s1;

	logic [phd_pkg::COLOR_W-1:0]   held_q;
	logic [phd_pkg::COLOR_W-1:0]   entry0_q;
	logic [phd_pkg::COLOR_W-1:0]   rdata;
	logic [phd_pkg::COLOR_W-1:0]   base;
	logic [phd_pkg::COLOR_W-1:0]   pal;
	logic [phd_pkg::COLOR_W-1:0]   next_colour;

	// replace the high bits of one held component
	function automatic logic [7:0] modify(input logic [7:0] c, input logic [5:0] d,
	                                      input logic w);
		return w ? {d, c[1:0]} : {d[3:0], c[3:0]};
	endfunction

	// issue control: one pixel per cycle while the result queue has room
	assign credit_ok = ({1'b0, out_level} + (phd_pkg::OUT_CW + 1)'(valid_s1))
	                   < (phd_pkg::OUT_CW + 1)'(phd_pkg::OUT_DEPTH);
	assign pix_go    = head_valid && (head.kind == phd_pkg::REQ_PIXELS) && credit_ok;
	assign wr_go     = head_valid && (head.kind == phd_pkg::REQ_PAL_WRITE);
	assign head_pop  = wr_go || (pix_go && (bit_q == 3'd7));
	assign wr_in_range = ({1'b0, head.pal_index} < 9'(phd_pkg::PALETTE_DEPTH));

	// colour index of the current pixel, plane 0 is the lsb
	always_comb begin
		planes = (cfg.plane_count > 4'(phd_pkg::MAX_PLANES)) ? 4'(phd_pkg::MAX_PLANES)
		         : cfg.plane_count;
		sel    = 3'd7 - bit_q;
		for (int p = 0; p < 8; p++) begin
			colour[p] = (4'(p) < planes) && head.plane_bytes[{3'(p), sel}];
		end
	end

	// classify the pixel: palette load, component modify or hold
	always_comb begin
		wide   = (planes == HAM8_PLANES);
		op     = OP_KEEP;
		hd     = colour[5:0];
		ld_idx = colour;
		if (!cfg.ham_enable) begin
			op = OP_LOAD;
		end else if (wide) begin
			ld_idx = {2'b00, colour[5:0]};
			case (colour[7:6])
				2'd0:    op = OP_LOAD;
				2'd1:    op = OP_MOD_B;
				2'd2:    op = OP_MOD_R;
				default: op = OP_MOD_G;
			endcase
		end else if (planes == HAM6_PLANES) begin
			hd     = {2'b00, colour[3:0]};
			ld_idx = {4'b0000, colour[3:0]};
			case (colour[5:4])
				2'd0:    op = OP_LOAD;
				2'd1:    op = OP_MOD_B;
				2'd2:    op = OP_MOD_R;
				default: op = OP_MOD_G;
			endcase
		end
		oob = ({1'b0, ld_idx} >= 9'(phd_pkg::PALETTE_DEPTH));
	end

	phd_ram #(
		.WIDTH (phd_pkg::COLOR_W),
		.DEPTH (phd_pkg::PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (wr_go && wr_in_range),
		.waddr (head.pal_index[phd_pkg::PAL_AW-1:0]),
		.wdata ({head.pal_red, head.pal_green, head.pal_blue}),
		.raddr (ld_idx[phd_pkg::PAL_AW-1:0]),
		.rdata (rdata)
	);

	// copy of palette entry 0 for row-start reloads
	always_ff @(posedge clk) begin
		if (wr_go && (head.pal_index == '0)) begin
			entry0_q <= {head.pal_red, head.pal_green, head.pal_blue};
		end
	end

	// pixel stage payload
	always_ff @(posedge clk) begin
		if (pix_go) begin
			op_s1     <= op;
			hd_s1     <= hd;
			wide_s1   <= wide;
			reload_s1 <= cfg.ham_enable && head.row_start && (bit_q == 3'd0);
			last_s1   <= (bit_q == 3'd7);
			oob_s1    <= oob;
		end
	end

	// held-colour update
	always_comb begin
		base = reload_s1 ? entry0_q : held_q;
		pal  = oob_s1 ? '0 : rdata;
		case (op_s1)
			OP_LOAD:  next_colour = pal;
			OP_MOD_B: next_colour = {base[23:8], modify(base[7:0], hd_s1, wide_s1)};
			OP_MOD_R: next_colour = {modify(base[23:16], hd_s1, wide_s1), base[15:0]};
			OP_MOD_G: next_colour = {base[23:16], modify(base[15:8], hd_s1, wide_s1),
			                         base[7:0]};
			default:  next_colour = base;
		endcase
	end

	assign out_push       = valid_s1;
	assign out_data.red   = next_colour[23:16];
	assign out_data.green = next_colour[15:8];
	assign out_data.blue  = next_colour[7:0];
	assign out_data.last  = last_s1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q    <= '0;
			valid_s1 <= 1'b0;
			held_q   <= '0;
		end else begin
			valid_s1 <= pix_go;
			if (pix_go) begin
				bit_q <= bit_q + 1'b1;
			end
			if (valid_s1) begin
				held_q <= next_colour;
			end
		end
	end

	// a pixel in the update stage was issued the cycle before
	a_s1_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(pix_go))
		else $error("pixel stage valid without an issue");

	// the result queue never overflows
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, out_level} + (phd_pkg::OUT_CW + 1)'(valid_s1))
		<= (phd_pkg::OUT_CW + 1)'(phd_pkg::OUT_DEPTH))
		else $error("result queue overrun");

	// the last pixel of an item comes from pixel position seven
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |-> ($past(bit_q) == 3'd7))
		else $error("last pixel out of position");

	// held colour moves only with a pixel in the update stage
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> (held_q == $past(held_q)))
		else $error("held colour changed without a pixel");

	// the item is released only at the end of its pixels
	a_pop_end: assert property (@(posedge clk) disable iff (!arst_n)
		(head_pop && head.kind == phd_pkg::REQ_PIXELS) |-> (bit_q == 3'd7))
		else $error("pixel item released early");

endmodule

// File: src/planar_ham_pixel_decoder.sv
// Top level of the planar hold-and-modify pixel decoder.
// A pixel item passes through the front queue, the pixel stage registers and the result queue.
// Each pixel item yields eight pixels, one pixel per cycle while the result queue has room, set by the
// single palette read port feeding the held-colour update; a palette write needs no result-queue room.
// Reset clears the queues, the held colour and the pixel sequencer, and sets plane_count to 8
// and ham_enable to 0; the palette is not cleared and holds no defined value until written.
`timescale 1ns / 1ps

module planar_ham_pixel_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           req_type,
	input  logic                           row_start,
	input  logic [63:0]                    plane_bytes,
	input  logic [7:0]                     pal_index,
	input  logic [7:0]                     pal_red,
	input  logic [7:0]                     pal_green,
	input  logic [7:0]                     pal_blue,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [phd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phd_pkg::CFG_DW-1:0]     cfg_data,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     pix_red,
	output logic [7:0]                     pix_green,
	output logic [7:0]                     pix_blue,
	output logic                           last_pixel
);

	phd_pkg::cfg_t                 cfg_q;
	logic                          head_valid;
	phd_pkg::item_t                head;
	logic                          head_pop;
	logic [phd_pkg::OUT_CW-1:0]    out_level;
	logic                          out_push;
	phd_pkg::pix_t                 out_data;
	phd_pkg::pix_t                 out_head;

	// configuration registers, written in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_count <= 4'd8;
			cfg_q.ham_enable  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				phd_pkg::REG_PLANE_COUNT: cfg_q.plane_count <= cfg_data[3:0];
				phd_pkg::REG_HAM_ENABLE:  cfg_q.ham_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	phd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.row_start   (row_start),
		.plane_bytes (plane_bytes),
		.pal_index   (pal_index),
		.pal_red     (pal_red),
		.pal_green   (pal_green),
		.pal_blue    (pal_blue),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop)
	);

	phd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.out_level  (out_level),
		.out_push   (out_push),
		.out_data   (out_data)
	);

	phd_out_queue u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_data),
		.level   (out_level),
		.empty   (empty),
		.pop     (pop),
		.head    (out_head)
	);

	assign pix_red    = out_head.red;
	assign pix_green  = out_head.green;
	assign pix_blue   = out_head.blue;
	assign last_pixel = out_head.last;

endmodule

// File: sim/planar_ham_pixel_decoder_test.sv
// Self-checking testbench of the planar hold-and-modify pixel decoder.
`timescale 1ns / 1ps

module planar_ham_pixel_decoder_test;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 18;
	localparam int PLAN_ROWS = 22;
	// palette entries filled up front: every index the random phases can select
	localparam int FILL_ENTRIES = 64;
	// register index that the block does not decode
	localparam logic [phd_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd9;

	typedef phd_pkg::pix_t [7:0] pix_burst_t;

	typedef struct packed {
		logic           set_mode;
		logic [3:0]     pc_val;
		logic [3:0]     ham_val;
		phd_pkg::item_t it;
		logic           typed;
		logic [23:0]    colour;
	} plan_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic                           req_type;
	logic                           row_start;
	logic [63:0]                    plane_bytes;
	logic [7:0]                     pal_index;
	logic [7:0]                     pal_red;
	logic [7:0]                     pal_green;
	logic [7:0]                     pal_blue;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [phd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [phd_pkg::CFG_DW-1:0]     cfg_data;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [7:0]                     pix_red;
	logic [7:0]                     pix_green;
	logic [7:0]                     pix_blue;
	logic                           last_pixel;

	// predictor state
	logic [23:0] pal_shadow [phd_pkg::PALETTE_DEPTH];
	logic [7:0]  hold_r;
	logic [7:0]  hold_g;
	logic [7:0]  hold_b;
	logic [3:0]  mode_planes;
	logic        mode_ham;

	phd_pkg::pix_t pixel_q [$];
	int   errors;
	int   cycles = 0;
	bit   steady;

	logic [3:0] phase_pc [PHASES] = '{4'd8, 4'd6, 4'd8, 4'd4, 4'd1, 4'd0, 4'd15, 4'd7, 4'd3,
		4'd6, 4'd2};
	bit phase_ham [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

	planar_ham_pixel_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.row_start   (row_start),
		.plane_bytes (plane_bytes),
		.pal_index   (pal_index),
		.pal_red     (pal_red),
		.pal_green   (pal_green),
		.pal_blue    (pal_blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.pop         (pop),
		.pix_red     (pix_red),
		.pix_green   (pix_green),
		.pix_blue    (pix_blue),
		.last_pixel  (last_pixel)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL planar_ham_pixel_decoder");
			$finish;
		end
	end

	function automatic void fetch_held(input logic [7:0] idx);
		hold_r = pal_shadow[idx][23:16];
		hold_g = pal_shadow[idx][15:8];
		hold_b = pal_shadow[idx][7:0];
	endfunction

	// Eight pixels of one pixel item; updates the held colour as it goes
	function automatic pix_burst_t decode_pixels(input phd_pkg::item_t it);
		pix_burst_t burst;
		int         planes;
		int         sh;
		logic [7:0] colour;
		planes = (mode_planes > phd_pkg::MAX_PLANES) ? phd_pkg::MAX_PLANES
		         : int'(mode_planes);
		if (mode_ham && it.row_start)
			fetch_held(8'd0);
		for (int k = 0; k < 8; k++) begin
			sh = 7 - k;
			colour = '0;
			for (int p = planes; p > 0; p--)
				colour = {colour[6:0], it.plane_bytes[8 * (p - 1) + sh]};
			if (mode_ham) begin
				if (planes == 8) begin
					case (colour[7:6])
						2'd0: fetch_held({2'b00, colour[5:0]});
						2'd1: hold_b = {colour[5:0], hold_b[1:0]};
						2'd2: hold_r = {colour[5:0], hold_r[1:0]};
						default: hold_g = {colour[5:0], hold_g[1:0]};
					endcase
				end else if (planes == 6) begin
					case (colour[5:4])
						2'd0: fetch_held({4'h0, colour[3:0]});
						2'd1: hold_b = {colour[3:0], hold_b[3:0]};
						2'd2: hold_r = {colour[3:0], hold_r[3:0]};
						default: hold_g = {colour[3:0], hold_g[3:0]};
					endcase
				end
			end else begin
				fetch_held(colour);
			end
			burst[k].red = hold_r;
			burst[k].green = hold_g;
			burst[k].blue = hold_b;
			burst[k].last = (k == 7);
		end
		return burst;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
			errors++;
		end
	endfunction

	// One input transaction; the expected pixels are queued at acceptance
	task automatic send_item(input phd_pkg::item_t it, input bit typed,
		input logic [23:0] colour);
		pix_burst_t burst;
		while (!steady && $urandom_range(99) < 36) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req_type <= it.kind;
		row_start <= it.row_start;
		plane_bytes <= it.plane_bytes;
		pal_index <= it.pal_index;
		pal_red <= it.pal_red;
		pal_green <= it.pal_green;
		pal_blue <= it.pal_blue;
		do @(posedge clk); while (full !== 1'b0);
		if (it.kind == phd_pkg::REQ_PAL_WRITE) begin
			pal_shadow[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
		end else begin
			burst = decode_pixels(it);
			for (int k = 0; k < 8; k++) begin
				if (typed) begin
					burst[k].red = colour[23:16];
					burst[k].green = colour[15:8];
					burst[k].blue = colour[7:0];
				end
				pixel_q.push_back(burst[k]);
			end
		end
	endtask

	// Wait until every pixel has come out and the block has gone quiet
	task automatic drain();
		push <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [phd_pkg::CFG_IDX_W-1:0] idx,
		input logic [phd_pkg::CFG_DW-1:0] data, input bit hold);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == phd_pkg::REG_PLANE_COUNT)
			mode_planes = data;
		else if (idx == phd_pkg::REG_HAM_ENABLE)
			mode_ham = data[0];
		if (!hold)
			cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input logic [3:0] pc, input logic [3:0] ham);
		drain();
		write_reg(phd_pkg::REG_PLANE_COUNT, pc, 1'b1);
		write_reg(phd_pkg::REG_HAM_ENABLE, ham, 1'b0);
	endtask

	// Result side: check each popped pixel, then pick the next pop at random
	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected pixel %02h %02h %02h last %0d", $time, pix_red,
					pix_green, pix_blue, last_pixel);
				errors++;
			end else begin
				check_field("red", pixel_q[0].red, pix_red);
				check_field("green", pixel_q[0].green, pix_green);
				check_field("blue", pixel_q[0].blue, pix_blue);
				check_field("last", {7'd0, pixel_q[0].last}, {7'd0, last_pixel});
				void'(pixel_q.pop_front());
			end
		end
		pop <= steady || ($urandom_range(99) >= 36);
	end

	// Stimulus
	initial begin
		plan_row_t       plan [PLAN_ROWS];
		phd_pkg::item_t  it;
		logic [2:0]      pad;
		int              row_pos;
		int              row_len;

		errors = 0;
		steady = 1'b0;
		hold_r = '0;
		hold_g = '0;
		hold_b = '0;
		mode_planes = 4'd8;
		mode_ham = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		req_type <= phd_pkg::REQ_PAL_WRITE;
		row_start <= 1'b0;
		plane_bytes <= '0;
		pal_index <= '0;
		pal_red <= '0;
		pal_green <= '0;
		pal_blue <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		// set_mode, planes, ham, {kind, row_start, bytes, index, r, g, b}, typed, colour
		plan = '{
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PAL_WRITE, 1'b0, 64'h0,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PAL_WRITE, 1'b1, 64'h0,
				8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, 24'h0},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PAL_WRITE, 1'b0, 64'h0,
				8'h80, 8'h12, 8'h34, 8'h56}, 1'b0, 24'h0},
			// plain eight planes: all zero, all ones, top plane only
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'h0,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h000000},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'hffff_ffff_ffff_ffff,
				8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 24'hffffff},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'hff00_0000_0000_0000,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h123456},
			// row start has no effect in plain mode
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b1, 64'h0123_4567_89ab_cdef,
				8'h5a, 8'ha5, 8'h3c, 8'hc3}, 1'b0, 24'h0},
			// eight-plane HAM
			'{1'b1, 4'd8, 4'd1, '{phd_pkg::REQ_PIXELS, 1'b1, 64'h0,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h000000},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'h40c0_8000_ff3f_0f55,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b1, 64'ha5a5_3c3c_f0f0_0ff0,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			// six-plane HAM, upper planes must not matter
			'{1'b1, 4'd6, 4'd1, '{phd_pkg::REQ_PIXELS, 1'b1, 64'hffff_0f33_5599_aac3,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'h0000_f00f_c33c_a55a,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			// HAM with an odd plane count keeps the held colour
			'{1'b1, 4'd5, 4'd1, '{phd_pkg::REQ_PIXELS, 1'b0, 64'h1234_5678_9abc_def0,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			// zero planes index entry 0, fifteen planes clamp to eight
			'{1'b1, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'hffff_ffff_ffff_ffff,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h000000},
			'{1'b1, 4'd15, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'hffff_ffff_ffff_ffff,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hffffff},
			'{1'b1, 4'd1, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'h0000_0000_0000_00a5,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			// HAM, zero planes, row start reloads entry 0
			'{1'b1, 4'd0, 4'd1, '{phd_pkg::REQ_PIXELS, 1'b1, 64'hdead_beef_cafe_f00d,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h000000},
			// only bit 0 of the enable write counts
			'{1'b1, 4'd8, 4'd2, '{phd_pkg::REQ_PIXELS, 1'b1, 64'h8001_4002_2004_1008,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PAL_WRITE, 1'b0, 64'h0,
				8'h80, 8'hab, 8'hcd, 8'hef}, 1'b0, 24'h0},
			'{1'b0, 4'd0, 4'd0, '{phd_pkg::REQ_PIXELS, 1'b0, 64'hff00_0000_0000_0000,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'habcdef},
			// nine planes clamp to eight-plane HAM
			'{1'b1, 4'd9, 4'd1, '{phd_pkg::REQ_PIXELS, 1'b1, 64'hc0c0_4040_8080_3f3f,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
			'{1'b1, 4'd7, 4'd1, '{phd_pkg::REQ_PIXELS, 1'b0, 64'h5a5a_c3c3_0ff0_9669,
				8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the low palette entries; pixel data of the random phases never selects an unwritten one
		for (int i = 0; i < FILL_ENTRIES; i++) begin
			it.kind = phd_pkg::REQ_PAL_WRITE;
			it.row_start = 1'($urandom_range(1));
			it.plane_bytes = {$urandom, $urandom};
			it.pal_index = i[7:0];
			it.pal_red = 8'($urandom_range(255));
			it.pal_green = 8'($urandom_range(255));
			it.pal_blue = 8'($urandom_range(255));
			send_item(it, 1'b0, 24'h0);
		end

		// Directed rows
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].set_mode)
				set_mode(plan[r].pc_val, plan[r].ham_val);
			send_item(plan[r].it, plan[r].typed, plan[r].colour);
		end

		// A write to an undecoded index must change nothing
		drain();
		write_reg(REG_SPARE, 4'($urandom_range(15)), 1'b0);

		// Random phases, one mode each; rows of pixel items open with a row start
		for (int ph = 0; ph < PHASES; ph++) begin
			pad = 3'($urandom_range(7));
			set_mode(phase_pc[ph], {pad, phase_ham[ph]});
			steady = (ph == 1);
			row_pos = 0;
			row_len = $urandom_range(3, 8);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.plane_bytes = {$urandom, $urandom};
				// plain mode above six planes: keep indices inside the filled entries
				if (!phase_ham[ph] && phase_pc[ph] > 4'd6)
					it.plane_bytes[63:48] = '0;
				it.pal_index = 8'($urandom_range(255));
				it.pal_red = 8'($urandom_range(255));
				it.pal_green = 8'($urandom_range(255));
				it.pal_blue = 8'($urandom_range(255));
				if ($urandom_range(99) < 20) begin
					it.kind = phd_pkg::REQ_PAL_WRITE;
					it.row_start = 1'($urandom_range(1));
				end else begin
					it.kind = phd_pkg::REQ_PIXELS;
					if ($urandom_range(99) < 10)
						it.row_start = 1'($urandom_range(1));
					else
						it.row_start = (row_pos == 0);
					row_pos++;
					if (row_pos >= row_len) begin
						row_pos = 0;
						row_len = $urandom_range(3, 8);
					end
				end
				send_item(it, 1'b0, 24'h0);
			end
			steady = 1'b0;
		end

		drain();
		if (errors == 0)
			$display("PASS planar_ham_pixel_decoder");
		else
			$display("FAIL planar_ham_pixel_decoder");
		$finish;
	end

endmodule
